// ----- sv/abv_pkg.sv -----
package abv_pkg;

  // Largest number of words in one report.
  localparam int MAX_RESULTS = 4;
  // Width of a stored sequence tag.
  localparam int TAG_W = 16;

  localparam logic [1:0] ACT_DATA = 2'd0;
  localparam logic [1:0] ACT_ACK  = 2'd1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_STALE = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_WRITE,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

// ----- sv/abv_ram.sv -----
module abv_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/abv_mod.sv -----
// Restoring remainder by a constant, one dividend bit per cycle, MSB first.
module abv_mod #(
  parameter int WINDOW = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [15:0]               dividend,
  output logic                      done,
  output logic [$clog2(WINDOW)-1:0] rem
);

  localparam int AW = $clog2(WINDOW);
  localparam logic [AW:0] WIN = (AW+1)'(WINDOW);

  logic        busy;
  logic [3:0]  cnt;
  logic [15:0] sh;
  logic [AW:0] trial;
  logic [AW:0] rem_next;

  always_comb begin
    trial = {rem, sh[15]};
    rem_next = (trial >= WIN) ? (trial - WIN) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
    end else if (busy) begin
      sh  <= {sh[14:0], 1'b0};
      rem <= rem_next[AW-1:0];
    end
  end

endmodule

// ----- sv/ack_vector_builder_top.sv -----
// Receiver-side ack vector builder.
// Input channel s_*: one transaction per item. s_tuser carries the action
// (data sequence number, ack-of-ack update, or ignored codes), s_tdata the
// 16-bit number. An ack-of-ack update only loads the register, no output.
// A data number is stored in the slot store (index = number mod WINDOW),
// then a report follows on m_*: one transaction per packed word, oldest
// sequence number in the most significant valid bit, final word
// right-aligned and marked by m_tlast. m_tuser gives the report status.
// Steps per data item: accept, the bit-serial modulo unit, a store write,
// then per word slot reads through the registered RAM port and a load
// of the output register. A number not beyond ack-of-ack skips the slot
// reads and gives a single empty word. Ack-of-ack and ignored items are
// taken in the idle state, which they do not leave.
// Only one item is in work at a time; s_tready is high only when idle.
// After reset the slot store is swept clear, one entry per cycle, over all
// WINDOW entries, with s_tready low.
// A stalled receiver (m_tready low) holds the output register; the word
// scan waits in front of it, nothing is lost.
module ack_vector_builder_top #(
  parameter int WINDOW     = 64,
  parameter int CHUNK_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] chunk_word, [20:16] bit_count,
                                 // [22:21] chunk_index, [39:23] begin_seq,
                                 // [56:40] end_seq, [63:57] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast    // last
);

  localparam int AW   = $clog2(WINDOW);
  localparam int CW   = $clog2(CHUNK_BITS + 1);
  localparam int TW   = abv_pkg::TAG_W + 1;
  localparam int SPAN = (WINDOW < abv_pkg::MAX_RESULTS * CHUNK_BITS) ?
                        WINDOW : abv_pkg::MAX_RESULTS * CHUNK_BITS;
  localparam logic [AW:0] WIN = (AW+1)'(WINDOW);

  abv_pkg::state_t state, state_next;

  // modulo unit handshake
  logic mod_start;
  logic mod_done;

  // item registers
  logic [15:0]   ack_q;
  logic [15:0]   val_q;
  logic [16:0]   begin_q;
  logic [AW-1:0] off_q;       // bits in report minus one (zero for a stale report)
  logic [1:0]    status_q;
  logic          beyond_q;

  // scan registers
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   issue_rem;
  logic          pending;
  logic [15:0]   s_cmp;
  logic [15:0]   word;
  logic [CW-1:0] cnt;
  logic [1:0]    cidx;
  logic          last_q;

  // output register
  logic [15:0] o_word;
  logic [4:0]  o_cnt;
  logic [1:0]  o_idx;
  logic [16:0] o_begin;
  logic [16:0] o_end;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [TW-1:0] ram_wdata;
  logic          ram_re;
  logic [TW-1:0] ram_rdata;
  logic [AW-1:0] vmod;

  // combinational helpers
  logic          s_acc;
  logic          data_acc;
  logic [15:0]   n_diff;
  logic          trunc;
  logic          hit;
  logic          seq_end;
  logic          fin_word;
  logic          issue;
  logic          out_free;
  logic          emit_load;
  logic [AW:0]   begin_addr;

  assign s_acc    = s_tvalid && s_tready;
  assign data_acc = s_acc && (s_tuser == abv_pkg::ACT_DATA);
  assign n_diff   = s_tdata - ack_q;
  assign trunc    = n_diff > 16'(SPAN);

  assign hit      = ram_rdata[TW-1] && (ram_rdata[TW-2:0] == s_cmp);
  assign seq_end  = (s_cmp == val_q);
  assign fin_word = (state == abv_pkg::ST_READ) && pending &&
                    ((cnt == CW'(CHUNK_BITS - 1)) || seq_end);
  assign issue    = (state == abv_pkg::ST_READ) && (issue_rem != '0) && !fin_word;
  assign out_free = !m_tvalid || m_tready;
  assign emit_load = (state == abv_pkg::ST_EMIT) && out_free;

  // slot address of the first reported number, wrapped into the window
  always_comb begin
    if ({1'b0, vmod} >= {1'b0, off_q}) begin
      begin_addr = {1'b0, vmod} - {1'b0, off_q};
    end else begin
      begin_addr = {1'b0, vmod} + WIN - {1'b0, off_q};
    end
  end

  assign mod_start = data_acc;

  abv_mod #(.WINDOW(WINDOW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (s_tdata),
    .done     (mod_done),
    .rem      (vmod)
  );

  abv_ram #(.WIDTH(TW), .DEPTH(WINDOW)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      abv_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(WINDOW - 1)) state_next = abv_pkg::ST_IDLE;
      end
      abv_pkg::ST_IDLE: begin
        if (data_acc) state_next = abv_pkg::ST_MOD;
      end
      abv_pkg::ST_MOD: begin
        if (mod_done) state_next = abv_pkg::ST_WRITE;
      end
      abv_pkg::ST_WRITE: begin
        state_next = beyond_q ? abv_pkg::ST_READ : abv_pkg::ST_EMIT;
      end
      abv_pkg::ST_READ: begin
        if (fin_word) state_next = abv_pkg::ST_EMIT;
      end
      abv_pkg::ST_EMIT: begin
        if (out_free) state_next = last_q ? abv_pkg::ST_IDLE : abv_pkg::ST_READ;
      end
      default: state_next = abv_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    case (state)
      abv_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      abv_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      abv_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = vmod;
        ram_wdata = {1'b1, val_q};
      end
      abv_pkg::ST_READ: begin
        ram_re = issue;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= abv_pkg::ST_CLEAR;
      clr_addr <= '0;
      ack_q    <= '0;
      pending  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == abv_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (s_acc && (s_tuser == abv_pkg::ACT_ACK)) ack_q <= s_tdata;
      pending <= issue;
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item and scan datapath
  always_ff @(posedge clk) begin
    if (data_acc) begin
      val_q    <= s_tdata;
      beyond_q <= s_tdata > ack_q;
      cnt      <= '0;
      word     <= '0;
      cidx     <= '0;
      last_q   <= 1'b0;
      if (!(s_tdata > ack_q)) begin
        status_q <= abv_pkg::STAT_STALE;
        begin_q  <= {1'b0, ack_q} + 17'd1;
        off_q    <= '0;
      end else if (trunc) begin
        status_q <= abv_pkg::STAT_TRUNC;
        begin_q  <= {1'b0, s_tdata} - 17'(SPAN - 1);
        off_q    <= AW'(SPAN - 1);
      end else begin
        status_q <= abv_pkg::STAT_OK;
        begin_q  <= {1'b0, ack_q} + 17'd1;
        off_q    <= AW'(n_diff - 16'd1);
      end
    end

    if (state == abv_pkg::ST_WRITE) begin
      rd_addr   <= begin_addr[AW-1:0];
      issue_rem <= {1'b0, off_q} + 1'b1;
      s_cmp     <= begin_q[15:0];
      if (!beyond_q) last_q <= 1'b1;
    end

    if (issue) begin
      rd_addr   <= (rd_addr == AW'(WINDOW - 1)) ? '0 : rd_addr + 1'b1;
      issue_rem <= issue_rem - 1'b1;
    end

    if ((state == abv_pkg::ST_READ) && pending) begin
      word  <= {word[14:0], hit};
      cnt   <= cnt + 1'b1;
      s_cmp <= s_cmp + 16'd1;
      if (fin_word) last_q <= seq_end;
    end

    if (emit_load) begin
      o_word  <= word;
      o_cnt   <= 5'(cnt);
      o_idx   <= cidx;
      o_begin <= begin_q;
      o_end   <= {1'b0, val_q} + 17'd1;
      m_tuser <= status_q;
      m_tlast <= last_q;
      word    <= '0;
      cnt     <= '0;
      cidx    <= cidx + 2'd1;
    end
  end

  assign m_tdata = {7'd0, o_end, o_begin, o_idx, o_cnt, o_word};

endmodule

// ----- sv/abv_checker.sv -----
module abv_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // held word stays put while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed under stall");

  // stale report is a single empty word
  a_stale: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == abv_pkg::STAT_STALE) |->
      m_tlast && (m_tdata[20:16] == 5'd0) && (m_tdata[22:21] == 2'd0))
    else $error("stale report malformed");

  // a real report covers a non-empty range and its words carry bits
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != abv_pkg::STAT_STALE) |->
      (m_tdata[39:23] < m_tdata[56:40]) && (m_tdata[20:16] != 5'd0))
    else $error("report range or bit count bad");

  // unused status code never leaves, padding stays zero
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= abv_pkg::STAT_TRUNC) && (m_tdata[63:57] == 7'd0))
    else $error("bad status or padding");

endmodule

bind ack_vector_builder_top abv_checker u_abv_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
